>>> src/circular_queue_with_cursor_defines.svh
// ----------------------------------------------------------------------------
// Circular queue with cursor: assertion macros
// Shared assertion helpers for the queue RTL. They assume a clock named
// clk_i and an active-low reset named rst_ni in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_QUEUE_WITH_CURSOR_DEFINES_SVH
`define CIRCULAR_QUEUE_WITH_CURSOR_DEFINES_SVH

// Property checked on every rising edge outside of reset.
`define CQC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen outside of reset.
`define CQC_ASSERT_NEVER(lbl, cond, msg) \
  `CQC_ASSERT(lbl, !(cond), msg)

`endif

>>> src/cqc_pkg.sv
// ----------------------------------------------------------------------------
// Circular queue with cursor: package
// Widths, opcodes, item types and ring index helpers used by the queue RTL.
// ----------------------------------------------------------------------------
package cqc_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned ELEM_W = 32;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned OP_W   = 3;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] LEN_MIN = CNT_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_ENQ       = 3'd0,
    OP_DEQ       = 3'd1,
    OP_PEEK_HEAD = 3'd2,
    OP_PEEK_TAIL = 3'd3,
    OP_GET_NEXT  = 3'd4
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ELEM_W-1:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic              ok;
    logic [ELEM_W-1:0] data_out;
    logic [CNT_W-1:0]  fill_count;
    logic              is_empty;
    logic              is_full;
  } out_item_t;

  // Status of one operation, known before the slot data returns.
  typedef struct packed {
    logic             ok;
    logic [CNT_W-1:0] fill_count;
    logic             is_empty;
    logic             is_full;
  } op_status_t;

  // One access to the slot memory.
  typedef struct packed {
    logic              we;
    logic              re;
    logic [IDX_W-1:0]  addr;
    logic [ELEM_W-1:0] wdata;
  } mem_req_t;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx,
                                               input logic [CNT_W-1:0] len);
    logic [CNT_W-1:0] nxt;
    nxt = {{(CNT_W-IDX_W){1'b0}}, idx} + LEN_MIN;
    return (nxt == len) ? '0 : nxt[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx,
                                               input logic [CNT_W-1:0] len);
    logic [CNT_W-1:0] last;
    last = len - LEN_MIN;
    return (idx == '0) ? last[IDX_W-1:0] : idx - IDX_W'(1);
  endfunction

endpackage

>>> src/cqc_ram.sv
// ----------------------------------------------------------------------------
// Circular queue with cursor: slot memory
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module cqc_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/cqc_ctrl.sv
// ----------------------------------------------------------------------------
// Circular queue with cursor: queue control
// Holds head, tail, count, cursor and the length register, decodes each
// operation and issues its slot memory access.
// ----------------------------------------------------------------------------
`include "circular_queue_with_cursor_defines.svh"

module cqc_ctrl import cqc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic             accept_i,
  input  in_item_t         item_i,
  output op_status_t       status_o,
  output mem_req_t         mem_req_o
);

  logic [CNT_W-1:0] len_q;
  logic [CNT_W-1:0] len;
  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] tail_q, tail_d;
  logic [IDX_W-1:0] cursor_q, cursor_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             fwd_q, fwd_d;
  logic             ok;
  logic [IDX_W-1:0] tail_prev;
  logic [IDX_W-1:0] head_prev;

  // A length of zero acts as one; anything past the memory acts as full depth.
  always_comb begin
    if (len_q == '0) begin
      len = LEN_MIN;
    end else if (len_q > DEPTH_C) begin
      len = DEPTH_C;
    end else begin
      len = len_q;
    end
  end

  assign tail_prev = idx_dec(tail_q, len);
  assign head_prev = idx_dec(head_q, len);

  always_comb begin
    head_d          = head_q;
    tail_d          = tail_q;
    cursor_d        = cursor_q;
    count_d         = count_q;
    fwd_d           = fwd_q;
    ok              = 1'b0;
    mem_req_o.we    = 1'b0;
    mem_req_o.re    = 1'b0;
    mem_req_o.addr  = head_q;
    mem_req_o.wdata = item_i.data_in;

    unique case (item_i.op)
      OP_ENQ: begin
        mem_req_o.addr = tail_q;
        if (count_q < len) begin
          mem_req_o.we = accept_i;
          tail_d       = idx_inc(tail_q, len);
          count_d      = count_q + LEN_MIN;
          ok           = 1'b1;
        end
      end
      OP_DEQ: begin
        if (count_q != '0) begin
          mem_req_o.re = accept_i;
          head_d       = idx_inc(head_q, len);
          count_d      = count_q - LEN_MIN;
          ok           = 1'b1;
        end
      end
      OP_PEEK_HEAD: begin
        fwd_d    = 1'b1;
        cursor_d = idx_inc(head_q, len);
        if (count_q != '0) begin
          mem_req_o.re = accept_i;
          ok           = 1'b1;
        end
      end
      OP_PEEK_TAIL: begin
        fwd_d          = 1'b0;
        cursor_d       = tail_prev;
        mem_req_o.addr = tail_prev;
        if (count_q != '0) begin
          mem_req_o.re = accept_i;
          cursor_d     = idx_dec(tail_prev, len);
          ok           = 1'b1;
        end
      end
      OP_GET_NEXT: begin
        mem_req_o.addr = cursor_q;
        if (count_q != '0) begin
          if (fwd_q) begin
            if (cursor_q != tail_q) begin
              mem_req_o.re = accept_i;
              cursor_d     = idx_inc(cursor_q, len);
              ok           = 1'b1;
            end
          end else if (cursor_q != head_prev) begin
            mem_req_o.re = accept_i;
            cursor_d     = idx_dec(cursor_q, len);
            ok           = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    status_o.ok         = ok;
    status_o.fill_count = count_d;
    status_o.is_empty   = (count_d == '0);
    status_o.is_full    = (count_d == len);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= DEPTH_C;
      head_q   <= '0;
      tail_q   <= '0;
      cursor_q <= '0;
      count_q  <= '0;
      fwd_q    <= 1'b0;
    end else if (cfg_we_i) begin
      // A length write empties the queue; slot contents stay.
      len_q    <= cfg_wdata_i;
      head_q   <= '0;
      tail_q   <= '0;
      cursor_q <= '0;
      count_q  <= '0;
      fwd_q    <= 1'b0;
    end else if (accept_i) begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      cursor_q <= cursor_d;
      count_q  <= count_d;
      fwd_q    <= fwd_d;
    end
  end

  `CQC_ASSERT(a_count_in_len, count_q <= len, "fill count exceeds active length")
  `CQC_ASSERT(a_ptrs_in_len, (head_q < len) && (tail_q < len), "head or tail outside ring")
  `CQC_ASSERT_NEVER(a_rw_same_cycle, mem_req_o.we && mem_req_o.re, "slot read and write together")
  `CQC_ASSERT(a_full_enq_holds, accept_i && !cfg_we_i && (item_i.op == OP_ENQ) && (count_q == len) |=> $stable(count_q), "enqueue into full queue changed count")

endmodule

>>> src/circular_queue_with_cursor.sv
// ----------------------------------------------------------------------------
// Circular queue with cursor: top level
// Ring-buffer FIFO of up to 16 32-bit elements with a browse cursor.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless in_stall_o is high and
// returns one result item for each, in order, via the read stage and the
// output register. The slot store is a single-port RAM with registered read
// data; queue pointers and status are updated when the item is accepted, so
// the next item may follow at once. A result waits in an output register
// while the downstream side stalls; one more item can be taken into the
// read stage behind it before the input stalls. Writing the length register
// empties the queue and must happen only while no item is in flight.

module circular_queue_with_cursor import cqc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o
);

  logic              accept;
  logic              pend_move;
  logic              pend_valid_q;
  logic              pend_rd_q;
  logic              out_valid_q;
  op_status_t        status;
  op_status_t        pend_status_q;
  mem_req_t          mem_req;
  logic [ELEM_W-1:0] rdata;
  out_item_t         out_item_q;

  assign pend_move  = pend_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = pend_valid_q && !pend_move;
  assign accept     = in_valid_i && !in_stall_o;

  cqc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .status_o   (status),
    .mem_req_o  (mem_req)
  );

  cqc_ram #(
    .Depth(DEPTH),
    .Width(ELEM_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_req.we),
    .re_i   (mem_req.re),
    .addr_i (mem_req.addr),
    .wdata_i(mem_req.wdata),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= accept || (pend_valid_q && !pend_move);
      out_valid_q  <= pend_move || (out_valid_q && out_stall_i);
    end
  end

  // Only items that read a slot return its data; an enqueue answers zero.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_status_q <= status;
      pend_rd_q     <= mem_req.re;
    end
    if (pend_move) begin
      out_item_q.ok         <= pend_status_q.ok;
      out_item_q.data_out   <= pend_rd_q ? rdata : '0;
      out_item_q.fill_count <= pend_status_q.fill_count;
      out_item_q.is_empty   <= pend_status_q.is_empty;
      out_item_q.is_full    <= pend_status_q.is_full;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> tb/circular_queue_with_cursor_test.sv
// ----------------------------------------------------------------------------
// Circular queue with cursor: block-level test
// Drives enqueue, dequeue, peek and cursor-walk items into the queue under
// random source gaps and sink stalls. A behavioral ring model in the bench
// predicts every result item, and the results are checked field by field in
// order. The active length is changed between phases, including the clamped
// values.
// ----------------------------------------------------------------------------
module circular_queue_with_cursor_test;
  import cqc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [ELEM_W-1:0] elem_t;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned IDLE_PCT    = 36;

  // Opcodes the block does not define; they must report status only.
  localparam logic [OP_W-1:0] OP_RSVD_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_HI  = 3'd7;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [CNT_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  in_item_t         in_item_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_item_t        out_item_o;

  circular_queue_with_cursor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Ring model state.
  elem_t            ring_slot [DEPTH];
  bit               slot_filled [DEPTH];
  int unsigned      ring_head, ring_tail, ring_fill, cursor_pos;
  bit               walk_fwd;
  logic [CNT_W-1:0] length_reg;

  out_item_t        pending_results [$];
  bit               idle_en = 1'b1;
  int unsigned      err_count, cycle_count, result_count, ok_count;
  int unsigned      length_writes;
  int unsigned      op_seen [8];

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned ring_len();
    if (length_reg < LEN_MIN) return 1;
    if (length_reg > DEPTH_C) return DEPTH;
    return int'(length_reg);
  endfunction

  function automatic void clear_ring();
    ring_head  = 0;
    ring_tail  = 0;
    ring_fill  = 0;
    cursor_pos = 0;
    walk_fwd   = 1'b0;
  endfunction

  // A stale cursor may point at a slot that was never written; such a get
  // next must not be issued.
  function automatic bit next_hits_blank_slot();
    int unsigned len;
    len = ring_len();
    if (ring_fill == 0) return 1'b0;
    if (walk_fwd && cursor_pos != ring_tail) return !slot_filled[cursor_pos];
    if (!walk_fwd && cursor_pos != (ring_head + len - 1) % len)
      return !slot_filled[cursor_pos];
    return 1'b0;
  endfunction

  function automatic out_item_t apply_queue_op(in_item_t it);
    out_item_t   res;
    int unsigned len;
    logic        ok;
    elem_t       rd;
    len = ring_len();
    ok  = 1'b0;
    rd  = '0;
    case (it.op)
      OP_ENQ: begin
        if (ring_fill < len) begin
          ring_slot[ring_tail]   = it.data_in;
          slot_filled[ring_tail] = 1'b1;
          ring_tail = (ring_tail + 1) % len;
          ring_fill++;
          ok = 1'b1;
        end
      end
      OP_DEQ: begin
        if (ring_fill != 0) begin
          rd = ring_slot[ring_head];
          ring_head = (ring_head + 1) % len;
          ring_fill--;
          ok = 1'b1;
        end
      end
      OP_PEEK_HEAD: begin
        walk_fwd   = 1'b1;
        cursor_pos = (ring_head + 1) % len;
        if (ring_fill != 0) begin
          rd = ring_slot[ring_head];
          ok = 1'b1;
        end
      end
      OP_PEEK_TAIL: begin
        walk_fwd   = 1'b0;
        cursor_pos = (ring_tail + len - 1) % len;
        if (ring_fill != 0) begin
          rd = ring_slot[cursor_pos];
          cursor_pos = (cursor_pos + len - 1) % len;
          ok = 1'b1;
        end
      end
      OP_GET_NEXT: begin
        if (ring_fill != 0) begin
          if (walk_fwd) begin
            if (cursor_pos != ring_tail) begin
              rd = ring_slot[cursor_pos];
              cursor_pos = (cursor_pos + 1) % len;
              ok = 1'b1;
            end
          end else if (cursor_pos != (ring_head + len - 1) % len) begin
            rd = ring_slot[cursor_pos];
            cursor_pos = (cursor_pos + len - 1) % len;
            ok = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.ok         = ok;
    res.data_out   = ok ? rd : '0;
    res.fill_count = CNT_W'(ring_fill);
    res.is_empty   = (ring_fill == 0);
    res.is_full    = (ring_fill == len);
    if (ok) ok_count++;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [ELEM_W-1:0] got,
                                 input logic [ELEM_W-1:0] want);
    if (err_count < 40)
      $display("[%0t] mismatch on %s: got 0x%0h, wanted 0x%0h", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    result_count++;
    if (pending_results.size() == 0) begin
      report_mismatch("unrequested result item", got.data_out, '0);
      return;
    end
    want = pending_results.pop_front();
    if (got.ok !== want.ok) report_mismatch("ok", ELEM_W'(got.ok), ELEM_W'(want.ok));
    if (got.data_out !== want.data_out) report_mismatch("data_out", got.data_out, want.data_out);
    if (got.fill_count !== want.fill_count)
      report_mismatch("fill_count", ELEM_W'(got.fill_count), ELEM_W'(want.fill_count));
    if (got.is_empty !== want.is_empty)
      report_mismatch("is_empty", ELEM_W'(got.is_empty), ELEM_W'(want.is_empty));
    if (got.is_full !== want.is_full)
      report_mismatch("is_full", ELEM_W'(got.is_full), ELEM_W'(want.is_full));
  endtask

  // Result sink: checks accepted items and stalls at random.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result(out_item_o);
    out_stall_i <= idle_en && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Holds the item until accepted; valid stays high into the next item
  // unless a gap is drawn.
  task automatic send_item(input logic [OP_W-1:0] op, input elem_t data);
    in_item_t it;
    it.op      = (op == OP_GET_NEXT && next_hits_blank_slot()) ? OP_PEEK_HEAD : op;
    it.data_in = data;
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    op_seen[it.op]++;
    pending_results.push_back(apply_queue_op(it));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [CNT_W-1:0] len);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    length_reg  = len;
    clear_ring();
    length_writes++;
  endtask

  function automatic elem_t pick_data();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return elem_t'($urandom());
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 32) return OP_ENQ;
    if (r < 52) return OP_DEQ;
    if (r < 62) return OP_PEEK_HEAD;
    if (r < 72) return OP_PEEK_TAIL;
    if (r < 95) return OP_GET_NEXT;
    return OP_W'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
  endfunction

  // Mostly single random operations, with a peek and one to six get-next items mixed in.
  task automatic run_traffic(input int unsigned n_items);
    int unsigned sent, steps;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        send_item($urandom_range(1) ? OP_PEEK_HEAD : OP_PEEK_TAIL, pick_data());
        steps = $urandom_range(6, 1);
        repeat (steps) send_item(OP_GET_NEXT, pick_data());
        sent += steps + 1;
      end else begin
        send_item(pick_op(), pick_data());
        sent++;
      end
    end
  endtask

  task automatic test_empty_queue();
    send_item(OP_DEQ, '1);
    send_item(OP_PEEK_HEAD, '0);
    send_item(OP_PEEK_TAIL, '0);
    send_item(OP_GET_NEXT, '0);
    send_item(OP_RSVD_LO, '1);
    send_item(OP_RSVD_HI, '1);
  endtask

  // Forward and backward walks over four elements, each running to its end.
  task automatic test_walks();
    send_item(OP_ENQ, 32'h0000_0000);
    send_item(OP_ENQ, 32'hFFFF_FFFF);
    send_item(OP_ENQ, 32'h5555_5555);
    send_item(OP_ENQ, 32'hAAAA_AAAA);
    send_item(OP_PEEK_HEAD, '0);
    repeat (4) send_item(OP_GET_NEXT, '0);
    send_item(OP_PEEK_TAIL, '0);
    repeat (4) send_item(OP_GET_NEXT, '0);
    send_item(OP_DEQ, '0);
    send_item(OP_RSVD_MID, '0);
  endtask

  // A length of one, and zero which acts as one: the second enqueue is full.
  task automatic test_length_limits();
    write_length(CNT_W'(1));
    send_item(OP_ENQ, 32'h8000_0001);
    send_item(OP_ENQ, 32'h7FFF_FFFE);
    write_length('0);
    send_item(OP_ENQ, 32'h0000_0001);
    send_item(OP_ENQ, 32'h8000_0000);
  endtask

  task automatic test_length_sweep();
    logic [CNT_W-1:0] sweep [7];
    sweep = '{5'd31, 5'd17, 5'd2, 5'd3, 5'd16, 5'd8, 5'd1};
    foreach (sweep[i]) begin
      write_length(sweep[i]);
      run_traffic(30);
    end
  endtask

  // Full rate in both directions first, then random gaps on a short ring.
  task automatic test_steady_stream();
    write_length(DEPTH_C);
    idle_en = 1'b0;
    run_traffic(120);
    wait_drained();
    idle_en = 1'b1;
    write_length(CNT_W'(4));
    run_traffic(90);
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) slot_filled[i] = 1'b0;
    length_reg = DEPTH_C;
    clear_ring();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_walks();
    test_length_limits();
    test_length_sweep();
    test_steady_stream();
    wait_drained();

    $display("Sent %0d enqueue, %0d dequeue, %0d peek, %0d get-next and %0d reserved items",
             op_seen[OP_ENQ], op_seen[OP_DEQ], op_seen[OP_PEEK_HEAD] + op_seen[OP_PEEK_TAIL],
             op_seen[OP_GET_NEXT],
             op_seen[OP_RSVD_LO] + op_seen[OP_RSVD_MID] + op_seen[OP_RSVD_HI]);
    $display("over %0d length settings; %0d results checked, %0d reported success.",
             length_writes, result_count, ok_count);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches found.", err_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/cqc_pkg.sv
src/cqc_ram.sv
src/cqc_ctrl.sv
src/circular_queue_with_cursor.sv
tb/circular_queue_with_cursor_test.sv
